/* src/pta_pkg.sv */
// Shared types and constants of the persistent threshold alarm engine.
// No dependencies; imported by pta_cond_eval and persistent_threshold_alarm.
package pta_pkg;

	localparam int MAX_SERVERS_DEF = 16;
	localparam int NUM_COND        = 4;
	localparam int TIME_W          = 32;
	localparam int PCT_W           = 7;
	localparam int SLOT_W          = 4;
	localparam int TALLY_W         = 5;

	// Condition positions in the flag vector and in a start-time row.
	localparam int COND_CPU  = 0;
	localparam int COND_MEM  = 1;
	localparam int COND_DISK = 2;
	localparam int COND_OFF  = 3;

	// Configuration register indexes.
	localparam logic [1:0] REG_CPU_THR  = 2'd0;
	localparam logic [1:0] REG_MEM_THR  = 2'd1;
	localparam logic [1:0] REG_DISK_THR = 2'd2;
	localparam logic [1:0] REG_HOLD_SEC = 2'd3;

	// Action codes of an input item.
	localparam logic ACTION_EVAL  = 1'b0;
	localparam logic ACTION_CLEAR = 1'b1;

	localparam logic [TIME_W-1:0]  MS_PER_SECOND      = 32'd1000;
	localparam logic [15:0]        HOLD_SECONDS_RESET = 16'd60;
	localparam logic [TIME_W-1:0]  HOLD_MS_RESET      =
		TIME_W'(32'(HOLD_SECONDS_RESET) * MS_PER_SECOND);
	localparam logic [TALLY_W-1:0] TALLY_MAX          = 5'd31;

	typedef struct packed {
		logic [TIME_W-1:0] since;
		logic              active;
		logic              fresh;
	} cond_res_t;

endpackage

/* src/pta_start_mem.sv */
// Start-time memory: one row per slot holding the four condition start times.
// Synchronous write, registered read. No dependencies.
module pta_start_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 128
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/pta_cond_eval.sv */
// Hold timer of one alarm condition: start-time update and activation test.
// Depends on pta_pkg for widths and the cond_res_t result type.
module pta_cond_eval import pta_pkg::*; (
	input  logic              holds,
	input  logic              was_active,
	input  logic              start_vld,
	input  logic [TIME_W-1:0] since_mem,
	input  logic [TIME_W-1:0] now,
	input  logic [TIME_W-1:0] hold_ms,
	output cond_res_t         res
);

	logic [TIME_W-1:0] since_old;
	logic [TIME_W-1:0] since_new;
	logic [TIME_W-1:0] elapsed;

	always_comb begin
		since_old = start_vld ? since_mem : '0;
		// A start at time zero is stored as one, since zero means not started.
		if (since_old != '0) begin
			since_new = since_old;
		end else if (now != '0) begin
			since_new = now;
		end else begin
			since_new = TIME_W'(1);
		end
		elapsed = now - since_new;

		if (holds) begin
			res.since  = since_new;
			res.active = was_active | (elapsed >= hold_ms);
		end else begin
			res.since  = '0;
			res.active = 1'b0;
		end
		res.fresh = res.active & ~was_active;
	end

endmodule

/* src/persistent_threshold_alarm.sv */
// Persistent threshold alarm: per-slot CPU, memory, disk and offline alarms with hold time.
// An accepted item waits in stage 1 while its start-time row is read, then its result is registered.
// A new item is accepted only once stage 1 is free, so the memory read and write-back never overlap.
// An output stall holds the finished result and the item behind it until the transfer.
// Reset (arst_n low) clears control, flags, start-valid bits and pass totals, and loads the reset configuration.
// The start-time memory itself is not swept; per-entry valid bits make it read as zero.
module persistent_threshold_alarm import pta_pkg::*; #(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	// Input item channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [SLOT_W-1:0]  server_slot,
	input  logic [PCT_W-1:0]   cpu_percent,
	input  logic [PCT_W-1:0]   memory_percent,
	input  logic [PCT_W-1:0]   disk_percent,
	input  logic               online,
	input  logic [TIME_W-1:0]  now_ms,
	input  logic               last_of_pass,

	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SLOT_W-1:0]  slot,
	output logic               new_alert,
	output logic               offline_active,
	output logic               cpu_active,
	output logic               memory_active,
	output logic               disk_active,
	output logic               pass_done,
	output logic               first_new_valid,
	output logic [SLOT_W-1:0]  first_new_slot,
	output logic [TALLY_W-1:0] active_count
);

	localparam int SLOT_AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int ROW_W   = NUM_COND * TIME_W;
	localparam logic [6:0] NUM_SLOTS = 7'(MAX_SERVERS);

	// ------------------------------------------------------------------
	// Configuration registers. The hold time is kept in milliseconds so the
	// evaluation path only compares; the multiply happens at the write.
	// ------------------------------------------------------------------
	logic [PCT_W-1:0]  cpu_thr_q;
	logic [PCT_W-1:0]  mem_thr_q;
	logic [PCT_W-1:0]  disk_thr_q;
	logic [TIME_W-1:0] hold_ms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_thr_q  <= '0;
			mem_thr_q  <= '0;
			disk_thr_q <= '0;
			hold_ms_q  <= HOLD_MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CPU_THR:  cpu_thr_q  <= cfg_data[PCT_W-1:0];
				REG_MEM_THR:  mem_thr_q  <= cfg_data[PCT_W-1:0];
				REG_DISK_THR: disk_thr_q <= cfg_data[PCT_W-1:0];
				REG_HOLD_SEC: hold_ms_q  <=
					TIME_W'({16'd0, cfg_data} * MS_PER_SECOND);
				default:      cpu_thr_q  <= cpu_thr_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 holds the accepted item while the memory row is read. The
	// input stalls while stage 1 is occupied, so a write-back always lands
	// before the next read and no forwarding is needed.
	// ------------------------------------------------------------------
	logic               busy_s1;
	logic               action_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [SLOT_AW-1:0] idx_s1;
	logic               in_range_s1;
	logic [PCT_W-1:0]   cpu_s1;
	logic [PCT_W-1:0]   mem_s1;
	logic [PCT_W-1:0]   disk_s1;
	logic               online_s1;
	logic [TIME_W-1:0]  now_s1;
	logic               last_s1;

	logic in_xfer;
	logic s1_fire;
	logic out_valid_q;

	assign in_stall = busy_s1;
	assign in_xfer  = in_valid && !in_stall;
	// Stage 1 retires when the output register is empty or being drained.
	assign s1_fire  = busy_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_xfer) begin
			busy_s1 <= 1'b1;
		end else if (s1_fire) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1   <= action;
			slot_s1     <= server_slot;
			idx_s1      <= SLOT_AW'(server_slot);
			in_range_s1 <= ({3'b000, server_slot} < NUM_SLOTS);
			cpu_s1      <= cpu_percent;
			mem_s1      <= memory_percent;
			disk_s1     <= disk_percent;
			online_s1   <= online;
			now_s1      <= now_ms;
			last_s1     <= last_of_pass;
		end
	end

	// ------------------------------------------------------------------
	// Start-time memory and per-slot state. A start time whose valid bit is
	// clear reads as zero, which stands for the cleared reset contents.
	// ------------------------------------------------------------------
	logic [ROW_W-1:0]    rd_row;
	logic [ROW_W-1:0]    wr_row;
	logic                mem_wr_en;

	logic [NUM_COND-1:0] flags_q [MAX_SERVERS];
	logic [NUM_COND-1:0] vld_q   [MAX_SERVERS];
	logic [MAX_SERVERS-1:0] seen_q;
	logic                found_q;
	logic [SLOT_W-1:0]   first_idx_q;
	logic [TALLY_W-1:0]  tally_q;

	pta_start_mem #(
		.DEPTH (MAX_SERVERS),
		.AW    (SLOT_AW),
		.DW    (ROW_W)
	) u_start_mem (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (SLOT_AW'(server_slot)),
		.rd_data (rd_row),
		.wr_en   (mem_wr_en),
		.wr_addr (idx_s1),
		.wr_data (wr_row)
	);

	// ------------------------------------------------------------------
	// Condition evaluation for the slot in stage 1.
	// ------------------------------------------------------------------
	logic [NUM_COND-1:0] hold_vec;
	logic [NUM_COND-1:0] was_vec;
	logic [NUM_COND-1:0] vld_row;
	cond_res_t           cres [NUM_COND];

	always_comb begin
		hold_vec[COND_CPU]  = (cpu_thr_q != '0) && (cpu_s1 >= cpu_thr_q);
		hold_vec[COND_MEM]  = (mem_thr_q != '0) && (mem_s1 >= mem_thr_q);
		hold_vec[COND_DISK] = (disk_thr_q != '0) && (disk_s1 >= disk_thr_q);
		hold_vec[COND_OFF]  = !online_s1;
		was_vec             = flags_q[idx_s1];
		vld_row             = vld_q[idx_s1];
	end

	for (genvar c = 0; c < NUM_COND; c++) begin : g_cond
		pta_cond_eval u_cond (
			.holds      (hold_vec[c]),
			.was_active (was_vec[c]),
			.start_vld  (vld_row[c]),
			.since_mem  (rd_row[c*TIME_W +: TIME_W]),
			.now        (now_s1),
			.hold_ms    (hold_ms_q),
			.res        (cres[c])
		);
		assign wr_row[c*TIME_W +: TIME_W] = cres[c].since;
	end

	logic                   eval_hit;
	logic [NUM_COND-1:0]    new_flags;
	logic                   fresh_any;
	logic [NUM_COND-1:0]    res_flags;
	logic                   res_fresh;
	logic [MAX_SERVERS-1:0] slot_hot;
	logic [MAX_SERVERS-1:0] seen_next;
	logic                   found_next;
	logic [SLOT_W-1:0]      first_idx_next;
	logic [TALLY_W-1:0]     tally_next;

	assign eval_hit  = (action_s1 == ACTION_EVAL) && in_range_s1;
	assign mem_wr_en = s1_fire && eval_hit;

	always_comb begin
		fresh_any = 1'b0;
		for (int c = 0; c < NUM_COND; c++) begin
			new_flags[c] = cres[c].active;
			fresh_any    = fresh_any | cres[c].fresh;
		end

		// Out-of-range slots report nothing; a clear reports the stored flags.
		if (!in_range_s1) begin
			res_flags = '0;
			res_fresh = 1'b0;
		end else if (action_s1 == ACTION_CLEAR) begin
			res_flags = was_vec;
			res_fresh = 1'b0;
		end else begin
			res_flags = new_flags;
			res_fresh = fresh_any;
		end

		for (int s = 0; s < MAX_SERVERS; s++) begin
			slot_hot[s] = (SLOT_AW'(s) == idx_s1);
		end
		seen_next = seen_q | (eval_hit ? slot_hot : '0);

		found_next     = found_q;
		first_idx_next = first_idx_q;
		if (eval_hit && fresh_any && !found_q) begin
			found_next     = 1'b1;
			first_idx_next = slot_s1;
		end

		tally_next = tally_q;
		if (eval_hit && (new_flags != '0) && (tally_q < TALLY_MAX)) begin
			tally_next = tally_q + TALLY_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Per-slot flags, start-valid bits and pass accumulators. A clear drops
	// the start times of inactive conditions; the end of a pass wipes every
	// slot that no sample touched during the pass.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SERVERS; s++) begin
				flags_q[s] <= '0;
				vld_q[s]   <= '0;
			end
			seen_q      <= '0;
			found_q     <= 1'b0;
			first_idx_q <= '0;
			tally_q     <= '0;
		end else if (s1_fire) begin
			if (action_s1 == ACTION_CLEAR) begin
				for (int s = 0; s < MAX_SERVERS; s++) begin
					vld_q[s] <= vld_q[s] & flags_q[s];
				end
			end else begin
				for (int s = 0; s < MAX_SERVERS; s++) begin
					if (eval_hit && slot_hot[s]) begin
						flags_q[s] <= new_flags;
						vld_q[s]   <= hold_vec;
					end
					if (last_s1 && !seen_next[s]) begin
						flags_q[s] <= '0;
						vld_q[s]   <= '0;
					end
				end
				if (last_s1) begin
					seen_q      <= '0;
					found_q     <= 1'b0;
					first_idx_q <= '0;
					tally_q     <= '0;
				end else begin
					seen_q      <= seen_next;
					found_q     <= found_next;
					first_idx_q <= first_idx_next;
					tally_q     <= tally_next;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register. It frees stage 1 so the next item can enter while a
	// finished result waits for its transfer.
	// ------------------------------------------------------------------
	logic               pass_end;
	logic [SLOT_W-1:0]  slot_q;
	logic               new_alert_q;
	logic [NUM_COND-1:0] flags_out_q;
	logic               pass_done_q;
	logic               first_valid_q;
	logic [SLOT_W-1:0]  first_slot_q;
	logic [TALLY_W-1:0] count_q;

	assign pass_end = (action_s1 == ACTION_EVAL) && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			slot_q        <= slot_s1;
			new_alert_q   <= res_fresh;
			flags_out_q   <= res_flags;
			pass_done_q   <= pass_end;
			first_valid_q <= pass_end && found_next;
			first_slot_q  <= (pass_end && found_next) ? first_idx_next : '0;
			count_q       <= pass_end ? tally_next : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign slot            = slot_q;
	assign new_alert       = new_alert_q;
	assign offline_active  = flags_out_q[COND_OFF];
	assign cpu_active      = flags_out_q[COND_CPU];
	assign memory_active   = flags_out_q[COND_MEM];
	assign disk_active     = flags_out_q[COND_DISK];
	assign pass_done       = pass_done_q;
	assign first_new_valid = first_valid_q;
	assign first_new_slot  = first_slot_q;
	assign active_count    = count_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	logic orphan_flag;

	always_comb begin
		orphan_flag = 1'b0;
		for (int s = 0; s < MAX_SERVERS; s++) begin
			orphan_flag = orphan_flag | (|(flags_q[s] & ~vld_q[s]));
		end
	end

	// An active condition always has a recorded start time.
	a_active_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		!orphan_flag)
		else $error("active alarm flag without a valid start time");

	// A result only appears after an item occupied stage 1.
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_s1))
		else $error("result produced without an item in stage 1");

	// A new alert is always reported together with an active flag.
	a_new_alert_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && new_alert_q |-> (flags_out_q != '0))
		else $error("new alert reported with no active condition");

	// Pass totals are zero outside the end of a pass.
	a_pass_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pass_done_q |-> !first_valid_q && (count_q == '0)
			&& (first_slot_q == '0))
		else $error("pass totals reported on a result that ends no pass");

	// Accepted items never overlap in stage 1.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> busy_s1 && !$past(busy_s1))
		else $error("item accepted while stage 1 was occupied");

endmodule

/* bench/persistent_threshold_alarm_test.sv */
// Self-checking testbench for persistent_threshold_alarm: directed rows, then random passes.
// Results are checked against a behavioral alarm engine kept inside this file.
// Depends on pta_pkg and the persistent_threshold_alarm RTL only.
module persistent_threshold_alarm_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pta_pkg::*;

	localparam int SLOTS = MAX_SERVERS_DEF;
	localparam int IDLE_PCT = 17;
	localparam int PHASE_ITEMS = 230;
	localparam int NUM_PHASES = 6;
	// Phase run with both sides streaming: no idle input cycles and no output stalls.
	localparam int CALM_PHASE = 3;
	// Directed row before which the thresholds are switched on.
	localparam int RECONFIG_ROW = 6;

	// One input transfer, in port order.
	typedef struct packed {
		logic              act;
		logic [SLOT_W-1:0] slot;
		logic [PCT_W-1:0]  cpu;
		logic [PCT_W-1:0]  mem;
		logic [PCT_W-1:0]  disk;
		logic              online;
		logic [TIME_W-1:0] now;
		logic              last;
	} item_t;

	// One result transfer, in port order.
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               fresh;
		logic               off;
		logic               cpu;
		logic               mem;
		logic               disk;
		logic               done;
		logic               first_ok;
		logic [SLOT_W-1:0]  first_slot;
		logic [TALLY_W-1:0] count;
	} result_t;

	typedef struct packed {
		logic [PCT_W-1:0]  cpu;
		logic [PCT_W-1:0]  mem;
		logic [PCT_W-1:0]  disk;
		logic [15:0]       hold;
		logic [TIME_W-1:0] t0;
	} settings_t;

	typedef struct packed {
		logic    typed;
		item_t   it;
		result_t want;
	} dir_row_t;

	localparam result_t NO_CHECK = '0;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               action = ACTION_EVAL;
	logic [SLOT_W-1:0]  server_slot = '0;
	logic [PCT_W-1:0]   cpu_percent = '0;
	logic [PCT_W-1:0]   memory_percent = '0;
	logic [PCT_W-1:0]   disk_percent = '0;
	logic               online = 1'b1;
	logic [TIME_W-1:0]  now_ms = '0;
	logic               last_of_pass = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SLOT_W-1:0]  slot;
	logic               new_alert;
	logic               offline_active;
	logic               cpu_active;
	logic               memory_active;
	logic               disk_active;
	logic               pass_done;
	logic               first_new_valid;
	logic [SLOT_W-1:0]  first_new_slot;
	logic [TALLY_W-1:0] active_count;

	persistent_threshold_alarm uut (.*);

	// Behavioral copy of the alarm engine: configuration, start times, flags, pass totals.
	bit [PCT_W-1:0]   thr_cpu;
	bit [PCT_W-1:0]   thr_mem;
	bit [PCT_W-1:0]   thr_disk;
	bit [15:0]        hold_sec = HOLD_SECONDS_RESET;
	bit [TIME_W-1:0]  since_ms [SLOTS][NUM_COND];
	bit [NUM_COND-1:0] alarm_bits [SLOTS];
	bit [SLOTS-1:0]   seen;
	bit [SLOT_W-1:0]  lead_slot;
	bit               lead_found;
	bit [TALLY_W-1:0] tally;

	result_t reports_due [$];
	int mismatches = 0;
	int items_sent = 0;
	bit calm = 1'b0;

	// Stimulus state: the simulated wall clock, the slots walked in each pass and,
	// per slot, which conditions are meant to hold so that alarms can persist.
	logic [TIME_W-1:0]   clock_ms;
	logic [SLOT_W-1:0]   roster [$];
	logic [NUM_COND-1:0] trend [SLOTS];

	// Directed rows. The first block runs with the reset configuration (all
	// thresholds off, 60 s hold), where only the offline condition can fire.
	// The rows with a typed result cover reset state, a start at time zero (stored
	// as one, so the elapsed time wraps to the maximum and the alarm fires at once)
	// and a pass end at the top of the time range.
	dir_row_t directed [17] = '{
		'{1'b1, '{ACTION_EVAL, 4'd0, 7'd127, 7'd127, 7'd127, 1'b1, 32'd0, 1'b0},
			'{4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 5'd0}},
		'{1'b1, '{ACTION_EVAL, 4'd15, 7'd0, 7'd0, 7'd0, 1'b0, 32'd0, 1'b0},
			'{4'd15, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 5'd0}},
		'{1'b0, '{ACTION_EVAL, 4'd15, 7'd0, 7'd0, 7'd0, 1'b0, 32'd1000, 1'b0}, NO_CHECK},
		'{1'b1, '{ACTION_EVAL, 4'd7, 7'd0, 7'd0, 7'd0, 1'b0, 32'hFFFF_FFFF, 1'b1},
			'{4'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 4'd15, 5'd2}},
		'{1'b0, '{ACTION_CLEAR, 4'd15, 7'd127, 7'd127, 7'd127, 1'b0, 32'hFFFF_FFFF, 1'b1},
			NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd7, 7'd0, 7'd0, 7'd0, 1'b0, 32'd59999, 1'b1}, NO_CHECK},
		// From here on: CPU at 50, memory at 100, disk at 1, zero hold time.
		'{1'b0, '{ACTION_EVAL, 4'd2, 7'd49, 7'd99, 7'd0, 1'b1, 32'd100, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd2, 7'd50, 7'd100, 7'd1, 1'b1, 32'd200, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd2, 7'd127, 7'd127, 7'd127, 1'b1, 32'd300, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd2, 7'd0, 7'd100, 7'd127, 1'b1, 32'd400, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd4, 7'd0, 7'd0, 7'd0, 1'b0, 32'd500, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd4, 7'd0, 7'd0, 7'd0, 1'b1, 32'd600, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd9, 7'd0, 7'd0, 7'd0, 1'b1, 32'd700, 1'b1}, NO_CHECK},
		'{1'b0, '{ACTION_CLEAR, 4'd2, 7'd0, 7'd0, 7'd0, 1'b1, 32'd0, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd2, 7'd0, 7'd100, 7'd1, 1'b0, 32'd0, 1'b0}, NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd11, 7'd85, 7'd42, 7'd85, 1'b1, 32'h8000_0000, 1'b1},
			NO_CHECK},
		'{1'b0, '{ACTION_EVAL, 4'd2, 7'd0, 7'd0, 7'd0, 1'b1, 32'd5, 1'b1}, NO_CHECK}
	};

	localparam settings_t DIRECTED_SETTINGS = '{7'd50, 7'd100, 7'd1, 16'd0, 32'd0};

	// Random phases. They cover zero and maximum hold time, thresholds at 0, 1,
	// 100 and 127, and start times close to the wrap of the millisecond clock.
	settings_t phases [NUM_PHASES] = '{
		'{7'd60, 7'd70, 7'd80, 16'd0, 32'd1000},
		'{7'd90, 7'd1, 7'd100, 16'd1, 32'd0},
		'{7'd127, 7'd127, 7'd127, 16'd2, 32'hFFFF_F000},
		'{7'd0, 7'd0, 7'd50, 16'd3, 32'd5000},
		'{7'd1, 7'd100, 7'd0, 16'd65535, 32'hFFFF_FFF0},
		'{7'd40, 7'd60, 7'd90, 16'd5, 32'h7FFF_FF00}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the result of one accepted transfer and advances the engine state.
	function automatic result_t alarm_engine_step(item_t it);
		result_t r;
		logic [NUM_COND-1:0] holds;
		logic [NUM_COND-1:0] flags;
		logic [TIME_W-1:0] hold_ms;
		logic fresh;
		r = '0;
		r.slot = it.slot;
		fresh = 1'b0;
		flags = '0;
		if (it.act == ACTION_CLEAR) begin
			// Pending timers of conditions that never fired are forgotten.
			for (int s = 0; s < SLOTS; s++)
				for (int c = 0; c < NUM_COND; c++)
					if (!alarm_bits[s][c])
						since_ms[s][c] = '0;
			flags = alarm_bits[it.slot];
		end else begin
			hold_ms = TIME_W'(32'(hold_sec) * MS_PER_SECOND);
			holds[COND_CPU] = thr_cpu != 0 && it.cpu >= thr_cpu;
			holds[COND_MEM] = thr_mem != 0 && it.mem >= thr_mem;
			holds[COND_DISK] = thr_disk != 0 && it.disk >= thr_disk;
			holds[COND_OFF] = !it.online;
			for (int c = 0; c < NUM_COND; c++) begin
				if (!holds[c]) begin
					since_ms[it.slot][c] = '0;
					alarm_bits[it.slot][c] = 1'b0;
				end else begin
					if (since_ms[it.slot][c] == 0)
						since_ms[it.slot][c] = (it.now == 0) ? 32'd1 : it.now;
					if (TIME_W'(it.now - since_ms[it.slot][c]) >= hold_ms) begin
						fresh |= !alarm_bits[it.slot][c];
						alarm_bits[it.slot][c] = 1'b1;
					end
				end
			end
			flags = alarm_bits[it.slot];
			seen[it.slot] = 1'b1;
			if (fresh && !lead_found) begin
				lead_found = 1'b1;
				lead_slot = it.slot;
			end
			if (flags != 0 && tally != TALLY_MAX)
				tally++;
			if (it.last) begin
				r.done = 1'b1;
				r.first_ok = lead_found;
				r.first_slot = lead_found ? lead_slot : '0;
				r.count = tally;
				// Slots missing from the pass lose their alarms and timers.
				for (int s = 0; s < SLOTS; s++)
					if (!seen[s]) begin
						alarm_bits[s] = '0;
						for (int c = 0; c < NUM_COND; c++)
							since_ms[s][c] = '0;
					end
				seen = '0;
				lead_found = 1'b0;
				lead_slot = '0;
				tally = '0;
			end
		end
		r.fresh = fresh;
		r.off = flags[COND_OFF];
		r.cpu = flags[COND_CPU];
		r.mem = flags[COND_MEM];
		r.disk = flags[COND_DISK];
		return r;
	endfunction

	// A percentage that meets or misses the threshold as asked, often right at the edge.
	function automatic logic [PCT_W-1:0] pick_pct(logic holds, logic [PCT_W-1:0] thr);
		if (thr == 0)
			return PCT_W'($urandom);
		if ($urandom_range(3) == 0)
			return holds ? thr : thr - 7'd1;
		return holds ? PCT_W'($urandom_range(127, thr)) : PCT_W'($urandom_range(thr - 7'd1));
	endfunction

	// An evaluation sample for slot s. Most follow the slot's trend; a tenth are noise.
	function automatic item_t make_sample(logic [SLOT_W-1:0] s);
		item_t it;
		it = item_t'(60'({$urandom, $urandom}));
		it.act = ACTION_EVAL;
		it.slot = s;
		it.last = 1'b0;
		clock_ms += TIME_W'($urandom_range(20));
		it.now = clock_ms;
		if ($urandom_range(9) != 0) begin
			it.cpu = pick_pct(trend[s][COND_CPU], thr_cpu);
			it.mem = pick_pct(trend[s][COND_MEM], thr_mem);
			it.disk = pick_pct(trend[s][COND_DISK], thr_disk);
			it.online = !trend[s][COND_OFF];
		end
		return it;
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		$display("%0t ns: mismatch, %s", $time, what);
	endtask

	task automatic check_field(string name, logic [4:0] got, logic [4:0] want,
			logic [SLOT_W-1:0] s);
		if (got !== want)
			note_mismatch($sformatf("%s of slot %0d: got %0d, expected %0d",
				name, s, got, want));
	endtask

	// Offers one item, waits for its transfer and queues what it must produce.
	// Called at a rising edge; returns at the edge of the transfer.
	task automatic offer_sample(item_t it, logic typed, result_t want);
		result_t predicted;
		if (!calm)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		action <= it.act;
		server_slot <= it.slot;
		cpu_percent <= it.cpu;
		memory_percent <= it.mem;
		disk_percent <= it.disk;
		online <= it.online;
		now_ms <= it.now;
		last_of_pass <= it.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = alarm_engine_step(it);
		reports_due.insert(reports_due.size(), typed ? want : predicted);
		items_sent++;
	endtask

	// Holds the input back until every expected result has arrived, then lets the
	// pipeline run empty.
	task automatic settle_engine();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes all four registers back to back; valid stays high between transfers.
	// Threshold writes carry random upper bits, which the block must ignore.
	task automatic load_settings(settings_t cfg);
		logic [15:0] word;
		for (int i = 0; i < 4; i++) begin
			case (2'(i))
				REG_CPU_THR: begin
					word = {9'($urandom), cfg.cpu};
					thr_cpu = cfg.cpu;
				end
				REG_MEM_THR: begin
					word = {9'($urandom), cfg.mem};
					thr_mem = cfg.mem;
				end
				REG_DISK_THR: begin
					word = {9'($urandom), cfg.disk};
					thr_disk = cfg.disk;
				end
				default: begin
					word = cfg.hold;
					hold_sec = cfg.hold;
				end
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= word;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// One evaluation pass over the roster. Time jumps between passes by up to about
	// half the hold time, so alarms need a few passes of a steady trend to fire.
	// Stray slots, skipped slots and clear actions are mixed in. A stretched pass
	// walks the roster until it is long enough to saturate the active count.
	task automatic run_pass(bit stretch);
		item_t batch [$];
		item_t it;
		logic [TIME_W-1:0] hold_ms;
		hold_ms = TIME_W'(32'(hold_sec) * MS_PER_SECOND);
		case ($urandom_range(19))
			0: clock_ms = $urandom;
			1: clock_ms = '0;
			default: clock_ms += TIME_W'($urandom_range(hold_ms / 2 + 300));
		endcase
		foreach (roster[i])
			for (int c = 0; c < NUM_COND; c++)
				if ($urandom_range(99) < 15)
					trend[roster[i]][c] = ~trend[roster[i]][c];
		do begin
			foreach (roster[i]) begin
				if ($urandom_range(9) != 0)
					batch.insert(batch.size(), make_sample(roster[i]));
				if ($urandom_range(99) < 8)
					batch.insert(batch.size(), make_sample(SLOT_W'($urandom)));
				if ($urandom_range(99) < 4) begin
					it = item_t'(60'({$urandom, $urandom}));
					it.act = ACTION_CLEAR;
					batch.insert(batch.size(), it);
				end
			end
		end while (stretch && batch.size() < 40);
		// The pass must close with an evaluation; a clear action never ends it.
		if (batch.size() == 0 || batch[batch.size() - 1].act == ACTION_CLEAR)
			batch.insert(batch.size(), make_sample(roster[0]));
		it = batch.pop_back();
		it.last = 1'b1;
		batch.insert(batch.size(), it);
		foreach (batch[i])
			offer_sample(batch[i], 1'b0, NO_CHECK);
	endtask

	// The result side stalls at random, except during the calm phase.
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	// Every result transfer is matched against the oldest outstanding expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reports_due.size() == 0) begin
				note_mismatch($sformatf("result for slot %0d with none outstanding", slot));
			end else begin
				want = reports_due.pop_front();
				check_field("slot", 5'(slot), 5'(want.slot), want.slot);
				check_field("new_alert", 5'(new_alert), 5'(want.fresh), want.slot);
				check_field("offline_active", 5'(offline_active), 5'(want.off),
					want.slot);
				check_field("cpu_active", 5'(cpu_active), 5'(want.cpu), want.slot);
				check_field("memory_active", 5'(memory_active), 5'(want.mem),
					want.slot);
				check_field("disk_active", 5'(disk_active), 5'(want.disk), want.slot);
				check_field("pass_done", 5'(pass_done), 5'(want.done), want.slot);
				check_field("first_new_valid", 5'(first_new_valid), 5'(want.first_ok),
					want.slot);
				check_field("first_new_slot", 5'(first_new_slot), 5'(want.first_slot),
					want.slot);
				check_field("active_count", active_count, want.count, want.slot);
			end
		end
	end

	initial begin
		int goal;
		bit opening;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; the thresholds come on before row RECONFIG_ROW.
		foreach (directed[i]) begin
			if (i == RECONFIG_ROW) begin
				settle_engine();
				load_settings(DIRECTED_SETTINGS);
			end
			offer_sample(directed[i].it, directed[i].typed, directed[i].want);
		end

		// Random phases, each with fresh settings, a fresh roster and fresh trends.
		// Settling before the writes also gives the pause with nothing in flight.
		foreach (phases[p]) begin
			settle_engine();
			load_settings(phases[p]);
			clock_ms = phases[p].t0;
			calm = (p == CALM_PHASE);
			roster.delete();
			repeat ($urandom_range(8, 1))
				roster.insert(roster.size(), SLOT_W'($urandom));
			foreach (trend[s])
				trend[s] = NUM_COND'($urandom);
			goal = items_sent + PHASE_ITEMS;
			opening = 1'b1;
			while (items_sent < goal) begin
				run_pass(opening || $urandom_range(9) == 0);
				opening = 1'b0;
				if ($urandom_range(19) == 0)
					settle_engine();
			end
		end

		settle_engine();
		if (mismatches == 0)
			$display("persistent_threshold_alarm test passed");
		else
			$display("persistent_threshold_alarm test failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("persistent_threshold_alarm test failed");
		$finish;
	end

endmodule

/* persistent_threshold_alarm.f */
src/pta_pkg.sv
src/pta_start_mem.sv
src/pta_cond_eval.sv
src/persistent_threshold_alarm.sv
bench/persistent_threshold_alarm_test.sv
